[design/bpa_pkg.sv]
package bpa_pkg;

  // sizes of the managed region
  localparam int TOP_ORDER     = 10;
  localparam int ORDERS        = TOP_ORDER + 1;
  localparam int PAGE_CAPACITY = 4096;
  localparam int IDX_W         = 12;
  localparam int CNT_W         = 13;
  localparam int ORD_W         = 4;

  // head flags are kept as words of 32 pages
  localparam int FW_SH   = 5;
  localparam int FW_BITS = 32;
  localparam int FW_AW   = IDX_W - FW_SH;
  localparam int SMALL_ORD = FW_SH;

  localparam logic [CNT_W-1:0] NO_LINK   = CNT_W'(PAGE_CAPACITY);
  localparam logic [CNT_W-1:0] REGION_MAX = CNT_W'(PAGE_CAPACITY);
  localparam logic [CNT_W-1:0] ALLOC_MAX = CNT_W'(1) << TOP_ORDER;

  // request codes
  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_FREE   = 2'd1;
  localparam logic [1:0] FUNC_FORMAT = 2'd2;

  // result codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_BADCNT = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  // datapath micro-operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_STAT,
    DP_FMT_INIT,
    DP_CLRW,
    DP_CARVE_INIT,
    DP_O_INC,
    DP_C_INIT,
    DP_C_INC,
    DP_A_TAKE,
    DP_A_SPLIT,
    DP_A_TAIL,
    DP_FREE_INIT,
    DP_OF_ZERO,
    DP_OF_INC,
    DP_OF_DEC,
    DP_FB_INIT,
    DP_FB_RD,
    DP_FB_MASKW,
    DP_FB_RDB,
    DP_FB_ARG_B,
    DP_FB_ARG_P,
    DP_FB_MRG,
    DP_FR_NEXT,
    DP_F_ARG,
    DP_P0,
    DP_P1,
    DP_U1,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] stat;
  } bpa_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cnt_zero;
    logic       cnt_big;
    logic       range_bad;
    logic       ord_short;
    logic       head_ok;
    logic       c_top;
    logic       c_above;
    logic       tail_left;
    logic       fr_go;
    logic       of_grow;
    logic       b_small;
    logic       blk_last;
    logic       sw_all;
    logic       b_top;
    logic       buddy_out;
    logic       buddy_free;
    logic       carve_fit;
    logic       of_zero;
  } bpa_sts_t;

endpackage

[design/buddy_page_allocator.sv]
// sequence: a rejected or unused request goes from decode to the result; alloc rounds the
//   count up to an order, searches the lists upward, unlinks the head, pushes split-off
//   upper halves and frees the tail; free walks aligned chunks, clearing head flags and merging
// throughput: one request at a time, set by the single controller walking the lists
// reset: rst_n synchronous active low; a pass over all 128 flag words clears the head flags,
//   and in_tready stays low until it ends
module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // page_count[12:0], base_index[24:13]
  input  logic [1:0]  in_tuser,  // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // block_index[11:0], status[13:12], free_total[26:14]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  bpa_pkg::bpa_cmd_t cmd;
  bpa_pkg::bpa_sts_t sts;
  logic [bpa_pkg::IDX_W-1:0] res_blk;
  logic [1:0]                res_stat;
  logic [bpa_pkg::CNT_W-1:0] res_free;
  logic                      cfg_wr;

  // register write strobe
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_tuser),
    .in_cnt    (in_tdata[12:0]),
    .in_base   (in_tdata[24:13]),
    .cfg_wr    (cfg_wr),
    .cfg_sel0  (!cfg_paddr[2]),
    .cfg_wdata (cfg_pwdata),
    .cfg_rdata (cfg_prdata),
    .res_blk   (res_blk),
    .res_stat  (res_stat),
    .res_free  (res_free)
  );

  // result word packing
  assign out_tdata = {5'd0, res_free, res_stat, res_blk};

endmodule

[design/bpa_dp.sv]
module bpa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpa_pkg::bpa_cmd_t            cmd,
  output bpa_pkg::bpa_sts_t            sts,
  input  logic [1:0]                   in_func,
  input  logic [bpa_pkg::CNT_W-1:0]    in_cnt,
  input  logic [bpa_pkg::IDX_W-1:0]    in_base,
  input  logic                         cfg_wr,
  input  logic                         cfg_sel0,
  input  logic [31:0]                  cfg_wdata,
  output logic [31:0]                  cfg_rdata,
  output logic [bpa_pkg::IDX_W-1:0]    res_blk,
  output logic [1:0]                   res_stat,
  output logic [bpa_pkg::CNT_W-1:0]    res_free
);

  localparam int CW = bpa_pkg::CNT_W;
  localparam int IW = bpa_pkg::IDX_W;
  localparam int OW = bpa_pkg::ORD_W;
  localparam int AW = bpa_pkg::FW_AW;
  localparam int SH = bpa_pkg::FW_SH;
  localparam int NB = bpa_pkg::FW_BITS;

  // request and configuration registers
  logic [1:0]    func_r, func_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] base_r, base_nxt;
  logic [CW-1:0] region_r;
  logic [1:0]    stat_r, stat_nxt;
  logic [IW-1:0] blk_r, blk_nxt;

  // walk registers
  logic [OW-1:0] o_r, o_nxt;
  logic [OW-1:0] c_r, c_nxt;
  logic [IW-1:0] page_r, page_nxt;
  logic [OW-1:0] of_r, of_nxt;
  logic [CW-1:0] fr_base_r, fr_base_nxt;
  logic [CW-1:0] fr_n_r, fr_n_nxt;
  logic [IW-1:0] b_idx_r, b_idx_nxt;
  logic [OW-1:0] b_ord_r, b_ord_nxt;
  logic [IW-1:0] arg_idx_r, arg_idx_nxt;
  logic [OW-1:0] arg_ord_r, arg_ord_nxt;
  logic [CW-1:0] h_r, h_nxt;
  logic [AW-1:0] sw_r, sw_nxt;

  // free list heads and free page total
  logic [CW-1:0] head_r [bpa_pkg::ORDERS];
  logic [CW-1:0] head_nxt [bpa_pkg::ORDERS];
  logic [CW-1:0] total_r, total_nxt;

  // result word
  logic [IW-1:0] out_blk_r, out_blk_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;
  logic [CW-1:0] out_free_r, out_free_nxt;

  // memories
  logic [NB-1:0] flag_mem  [2**AW];
  logic [OW-1:0] order_mem [bpa_pkg::PAGE_CAPACITY];
  logic [CW-1:0] next_mem  [bpa_pkg::PAGE_CAPACITY];
  logic [CW-1:0] prev_mem  [bpa_pkg::PAGE_CAPACITY];
  logic [NB-1:0] flag_rd_r;
  logic [OW-1:0] order_rd_r;
  logic [CW-1:0] next_rd_r;
  logic [CW-1:0] prev_rd_r;

  logic          flag_we;
  logic [AW-1:0] flag_waddr, flag_raddr;
  logic [NB-1:0] flag_wdata;
  logic          order_we;
  logic          next_we;
  logic [IW-1:0] next_waddr;
  logic [CW-1:0] next_wdata;
  logic          prev_we;
  logic [IW-1:0] prev_waddr;
  logic [CW-1:0] prev_wdata;

  // derived values
  logic [CW-1:0] lim;
  logic [CW:0]   pow_o;
  logic [CW:0]   pow_of;
  logic [CW+1:0] pow2_of;
  logic [CW-1:0] pow_a;
  logic [IW-1:0] pow_c1;
  logic [IW-1:0] buddy;
  logic [CW-1:0] head_c;
  logic [CW-1:0] head_a;
  logic [5:0]    run_len;
  logic [NB-1:0] run_bits;
  logic [NB-1:0] small_mask;
  logic [NB-1:0] arg_bit;
  logic [OW-1:0] wshift;
  logic [AW-1:0] wmask;

  assign lim      = (region_r > bpa_pkg::REGION_MAX) ? bpa_pkg::REGION_MAX : region_r;
  assign pow_o    = (CW+1)'(1) << o_r;
  assign pow_of   = (CW+1)'(1) << of_r;
  assign pow2_of  = (CW+2)'(2) << of_r;
  assign pow_a    = CW'(1) << arg_ord_r;
  assign pow_c1   = IW'(1) << (c_r - OW'(1));
  assign buddy    = b_idx_r ^ (IW'(1) << b_ord_r);
  assign head_c   = head_r[c_r];
  assign head_a   = head_r[arg_ord_r];
  assign run_len  = 6'(1) << b_ord_r;
  assign run_bits = NB'(((NB+1)'(1) << run_len) - (NB+1)'(1));
  assign small_mask = run_bits << b_idx_r[SH-1:0];
  assign arg_bit  = NB'(1) << arg_idx_r[SH-1:0];
  assign wshift   = b_ord_r - OW'(SH);
  assign wmask    = AW'(((AW+1)'(1) << wshift) - (AW+1)'(1));

  // status toward the controller
  always_comb begin
    sts.func       = func_r;
    sts.cnt_zero   = (cnt_r == '0);
    sts.cnt_big    = (cnt_r > bpa_pkg::ALLOC_MAX);
    sts.range_bad  = ((CW+1)'(base_r) + (CW+1)'(cnt_r)) > (CW+1)'(lim);
    sts.ord_short  = pow_o < (CW+1)'(cnt_r);
    sts.head_ok    = !head_c[CW-1];
    sts.c_top      = (c_r == OW'(bpa_pkg::TOP_ORDER));
    sts.c_above    = (c_r > o_r);
    sts.tail_left  = ((CW+1)'(cnt_r) != pow_o);
    sts.fr_go      = (fr_n_r != '0) && (fr_base_r < bpa_pkg::REGION_MAX);
    sts.of_grow    = (of_r < OW'(bpa_pkg::TOP_ORDER)) && !fr_base_r[of_r] &&
                     (pow2_of <= (CW+2)'(fr_n_r));
    sts.b_small    = (b_ord_r <= OW'(bpa_pkg::SMALL_ORD));
    sts.blk_last   = &(sw_r | ~wmask);
    sts.sw_all     = &sw_r;
    sts.b_top      = (b_ord_r == OW'(bpa_pkg::TOP_ORDER));
    sts.buddy_out  = (CW'(buddy) >= lim);
    sts.buddy_free = flag_rd_r[buddy[SH-1:0]] && (order_rd_r == b_ord_r);
    sts.carve_fit  = ((CW+1)'(fr_n_r) >= pow_of);
    sts.of_zero    = (of_r == '0);
  end

  // micro-operation decode
  always_comb begin
    func_nxt     = func_r;
    cnt_nxt      = cnt_r;
    base_nxt     = base_r;
    stat_nxt     = stat_r;
    blk_nxt      = blk_r;
    o_nxt        = o_r;
    c_nxt        = c_r;
    page_nxt     = page_r;
    of_nxt       = of_r;
    fr_base_nxt  = fr_base_r;
    fr_n_nxt     = fr_n_r;
    b_idx_nxt    = b_idx_r;
    b_ord_nxt    = b_ord_r;
    arg_idx_nxt  = arg_idx_r;
    arg_ord_nxt  = arg_ord_r;
    h_nxt        = h_r;
    sw_nxt       = sw_r;
    head_nxt     = head_r;
    total_nxt    = total_r;
    out_blk_nxt  = out_blk_r;
    out_stat_nxt = out_stat_r;
    out_free_nxt = out_free_r;
    flag_we      = 1'b0;
    flag_waddr   = arg_idx_r[IW-1:SH];
    flag_wdata   = flag_rd_r;
    flag_raddr   = arg_idx_r[IW-1:SH];
    order_we     = 1'b0;
    next_we      = 1'b0;
    next_waddr   = arg_idx_r;
    next_wdata   = head_a;
    prev_we      = 1'b0;
    prev_waddr   = arg_idx_r;
    prev_wdata   = bpa_pkg::NO_LINK;
    case (cmd.op)
      bpa_pkg::DP_LOAD: begin
        func_nxt = in_func;
        cnt_nxt  = in_cnt;
        base_nxt = in_base;
        stat_nxt = bpa_pkg::ST_OK;
        blk_nxt  = '0;
        o_nxt    = '0;
      end
      bpa_pkg::DP_STAT: begin
        stat_nxt = cmd.stat;
      end
      bpa_pkg::DP_FMT_INIT: begin
        for (int i = 0; i < bpa_pkg::ORDERS; i++) begin
          head_nxt[i] = bpa_pkg::NO_LINK;
        end
        total_nxt = '0;
        sw_nxt    = '0;
      end
      bpa_pkg::DP_CLRW: begin
        flag_we    = 1'b1;
        flag_waddr = sw_r;
        flag_wdata = '0;
        sw_nxt     = sw_r + AW'(1);
      end
      bpa_pkg::DP_CARVE_INIT: begin
        fr_n_nxt    = lim;
        fr_base_nxt = '0;
        of_nxt      = OW'(bpa_pkg::TOP_ORDER);
      end
      bpa_pkg::DP_O_INC: begin
        o_nxt = o_r + OW'(1);
      end
      bpa_pkg::DP_C_INIT: begin
        c_nxt = o_r;
      end
      bpa_pkg::DP_C_INC: begin
        c_nxt = c_r + OW'(1);
      end
      bpa_pkg::DP_A_TAKE: begin
        page_nxt    = head_c[IW-1:0];
        blk_nxt     = head_c[IW-1:0];
        arg_idx_nxt = head_c[IW-1:0];
        arg_ord_nxt = c_r;
      end
      bpa_pkg::DP_A_SPLIT: begin
        c_nxt       = c_r - OW'(1);
        arg_ord_nxt = c_r - OW'(1);
        arg_idx_nxt = page_r + pow_c1;
      end
      bpa_pkg::DP_A_TAIL: begin
        fr_base_nxt = CW'(page_r) + cnt_r;
        fr_n_nxt    = pow_o[CW-1:0] - cnt_r;
      end
      bpa_pkg::DP_FREE_INIT: begin
        fr_base_nxt = CW'(base_r);
        fr_n_nxt    = cnt_r;
      end
      bpa_pkg::DP_OF_ZERO: begin
        of_nxt = '0;
      end
      bpa_pkg::DP_OF_INC: begin
        of_nxt = of_r + OW'(1);
      end
      bpa_pkg::DP_OF_DEC: begin
        of_nxt = of_r - OW'(1);
      end
      bpa_pkg::DP_FB_INIT: begin
        b_idx_nxt = fr_base_r[IW-1:0];
        b_ord_nxt = of_r;
        sw_nxt    = fr_base_r[IW-1:SH];
      end
      bpa_pkg::DP_FB_RD: begin
        flag_raddr = b_idx_r[IW-1:SH];
      end
      bpa_pkg::DP_FB_MASKW: begin
        flag_we    = 1'b1;
        flag_waddr = b_idx_r[IW-1:SH];
        flag_wdata = flag_rd_r & ~small_mask;
      end
      bpa_pkg::DP_FB_RDB: begin
        flag_raddr = buddy[IW-1:SH];
      end
      bpa_pkg::DP_FB_ARG_B: begin
        arg_idx_nxt = buddy;
        arg_ord_nxt = b_ord_r;
      end
      bpa_pkg::DP_FB_ARG_P: begin
        arg_idx_nxt = b_idx_r;
        arg_ord_nxt = b_ord_r;
      end
      bpa_pkg::DP_FB_MRG: begin
        b_idx_nxt = b_idx_r & buddy;
        b_ord_nxt = b_ord_r + OW'(1);
      end
      bpa_pkg::DP_FR_NEXT: begin
        fr_base_nxt = fr_base_r + pow_of[CW-1:0];
        fr_n_nxt    = fr_n_r - pow_of[CW-1:0];
      end
      bpa_pkg::DP_F_ARG: begin
        arg_idx_nxt = fr_base_r[IW-1:0];
        arg_ord_nxt = of_r;
      end
      // push, first step: link the new head and fetch its flag word
      bpa_pkg::DP_P0: begin
        h_nxt      = head_a;
        next_we    = 1'b1;
        next_wdata = head_a;
        prev_we    = 1'b1;
        prev_wdata = bpa_pkg::NO_LINK;
        order_we   = 1'b1;
        head_nxt[arg_ord_r] = CW'(arg_idx_r);
        total_nxt  = total_r + pow_a;
      end
      // push, second step: back link of the old head, set the flag
      bpa_pkg::DP_P1: begin
        prev_we    = !h_r[CW-1];
        prev_waddr = h_r[IW-1:0];
        prev_wdata = CW'(arg_idx_r);
        flag_we    = 1'b1;
        flag_wdata = flag_rd_r | arg_bit;
      end
      // unlink: links were read in the cycle before
      bpa_pkg::DP_U1: begin
        if (!prev_rd_r[CW-1]) begin
          next_we = 1'b1;
        end else begin
          head_nxt[arg_ord_r] = next_rd_r;
        end
        next_waddr = prev_rd_r[IW-1:0];
        next_wdata = next_rd_r;
        prev_we    = !next_rd_r[CW-1];
        prev_waddr = next_rd_r[IW-1:0];
        prev_wdata = prev_rd_r;
        total_nxt  = total_r - pow_a;
        flag_we    = 1'b1;
        flag_wdata = flag_rd_r & ~arg_bit;
      end
      bpa_pkg::DP_OUT: begin
        out_blk_nxt  = blk_r;
        out_stat_nxt = stat_r;
        out_free_nxt = total_r;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= '0;
      sw_r     <= '0;
      total_r  <= '0;
      for (int i = 0; i < bpa_pkg::ORDERS; i++) begin
        head_r[i] <= bpa_pkg::NO_LINK;
      end
    end else begin
      if (cfg_wr && cfg_sel0) begin
        region_r <= cfg_wdata[CW-1:0];
      end
      sw_r    <= sw_nxt;
      total_r <= total_nxt;
      head_r  <= head_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    cnt_r      <= cnt_nxt;
    base_r     <= base_nxt;
    stat_r     <= stat_nxt;
    blk_r      <= blk_nxt;
    o_r        <= o_nxt;
    c_r        <= c_nxt;
    page_r     <= page_nxt;
    of_r       <= of_nxt;
    fr_base_r  <= fr_base_nxt;
    fr_n_r     <= fr_n_nxt;
    b_idx_r    <= b_idx_nxt;
    b_ord_r    <= b_ord_nxt;
    arg_idx_r  <= arg_idx_nxt;
    arg_ord_r  <= arg_ord_nxt;
    h_r        <= h_nxt;
    out_blk_r  <= out_blk_nxt;
    out_stat_r <= out_stat_nxt;
    out_free_r <= out_free_nxt;
  end

  // flag words, block orders and list links
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rd_r <= flag_mem[flag_raddr];
    if (order_we) begin
      order_mem[arg_idx_r] <= arg_ord_r;
    end
    order_rd_r <= order_mem[buddy];
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd_r <= next_mem[arg_idx_r];
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_rd_r <= prev_mem[arg_idx_r];
  end

  assign cfg_rdata = cfg_sel0 ? 32'(region_r) : 32'd0;
  assign res_blk   = out_blk_r;
  assign res_stat  = out_stat_r;
  assign res_free  = out_free_r;

endmodule

[design/bpa_ctrl.sv]
module bpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bpa_pkg::bpa_sts_t  sts,
  output bpa_pkg::bpa_cmd_t  cmd
);

  localparam int NS = 23;

  typedef enum logic [NS-1:0] {
    S_INIT    = NS'(1) << 0,
    S_IDLE    = NS'(1) << 1,
    S_DECODE  = NS'(1) << 2,
    S_A_ORD   = NS'(1) << 3,
    S_A_SRCH  = NS'(1) << 4,
    S_A_SPLIT = NS'(1) << 5,
    S_FR_TOP  = NS'(1) << 6,
    S_FR_ORD  = NS'(1) << 7,
    S_FB_CLR  = NS'(1) << 8,
    S_FB_MASK = NS'(1) << 9,
    S_FB_CHK  = NS'(1) << 10,
    S_FB_TST  = NS'(1) << 11,
    S_FB_MRG  = NS'(1) << 12,
    S_FR_NEXT = NS'(1) << 13,
    S_F_CLR   = NS'(1) << 14,
    S_F_CI    = NS'(1) << 15,
    S_F_CARVE = NS'(1) << 16,
    S_F_ADV   = NS'(1) << 17,
    S_P0      = NS'(1) << 18,
    S_P1      = NS'(1) << 19,
    S_U0      = NS'(1) << 20,
    S_U1      = NS'(1) << 21,
    S_RESULT  = NS'(1) << 22
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd.op    = bpa_pkg::DP_NOP;
    cmd.stat  = bpa_pkg::ST_OK;
    case (state_r)
      S_INIT: begin
        cmd.op = bpa_pkg::DP_CLRW;
        if (sts.sw_all) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = bpa_pkg::DP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.func)
          bpa_pkg::FUNC_ALLOC: begin
            if (sts.cnt_zero || sts.cnt_big) begin
              cmd.op    = bpa_pkg::DP_STAT;
              cmd.stat  = bpa_pkg::ST_BADCNT;
              state_nxt = S_RESULT;
            end else begin
              state_nxt = S_A_ORD;
            end
          end
          bpa_pkg::FUNC_FREE: begin
            if (sts.cnt_zero) begin
              cmd.op    = bpa_pkg::DP_STAT;
              cmd.stat  = bpa_pkg::ST_BADCNT;
              state_nxt = S_RESULT;
            end else if (sts.range_bad) begin
              cmd.op    = bpa_pkg::DP_STAT;
              cmd.stat  = bpa_pkg::ST_RANGE;
              state_nxt = S_RESULT;
            end else begin
              cmd.op    = bpa_pkg::DP_FREE_INIT;
              state_nxt = S_FR_TOP;
            end
          end
          bpa_pkg::FUNC_FORMAT: begin
            cmd.op    = bpa_pkg::DP_FMT_INIT;
            state_nxt = S_F_CLR;
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end
      // round the count up to a power of two
      S_A_ORD: begin
        if (sts.ord_short) begin
          cmd.op = bpa_pkg::DP_O_INC;
        end else begin
          cmd.op    = bpa_pkg::DP_C_INIT;
          state_nxt = S_A_SRCH;
        end
      end
      // smallest non-empty list at or above the order
      S_A_SRCH: begin
        if (sts.head_ok) begin
          cmd.op    = bpa_pkg::DP_A_TAKE;
          ret_nxt   = S_A_SPLIT;
          state_nxt = S_U0;
        end else if (sts.c_top) begin
          cmd.op    = bpa_pkg::DP_STAT;
          cmd.stat  = bpa_pkg::ST_NOFREE;
          state_nxt = S_RESULT;
        end else begin
          cmd.op = bpa_pkg::DP_C_INC;
        end
      end
      // push upper halves, then give back the unused tail
      S_A_SPLIT: begin
        if (sts.c_above) begin
          cmd.op    = bpa_pkg::DP_A_SPLIT;
          ret_nxt   = S_A_SPLIT;
          state_nxt = S_P0;
        end else if (sts.tail_left) begin
          cmd.op    = bpa_pkg::DP_A_TAIL;
          state_nxt = S_FR_TOP;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      // range free: one aligned chunk at a time
      S_FR_TOP: begin
        if (sts.fr_go) begin
          cmd.op    = bpa_pkg::DP_OF_ZERO;
          state_nxt = S_FR_ORD;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_FR_ORD: begin
        if (sts.of_grow) begin
          cmd.op = bpa_pkg::DP_OF_INC;
        end else begin
          cmd.op    = bpa_pkg::DP_FB_INIT;
          state_nxt = S_FB_CLR;
        end
      end
      // clear head flags over the chunk
      S_FB_CLR: begin
        if (sts.b_small) begin
          cmd.op    = bpa_pkg::DP_FB_RD;
          state_nxt = S_FB_MASK;
        end else begin
          cmd.op = bpa_pkg::DP_CLRW;
          if (sts.blk_last) begin
            state_nxt = S_FB_CHK;
          end
        end
      end
      S_FB_MASK: begin
        cmd.op    = bpa_pkg::DP_FB_MASKW;
        state_nxt = S_FB_CHK;
      end
      // merge with a free buddy of equal order
      S_FB_CHK: begin
        if (sts.b_top || sts.buddy_out) begin
          cmd.op    = bpa_pkg::DP_FB_ARG_P;
          ret_nxt   = S_FR_NEXT;
          state_nxt = S_P0;
        end else begin
          cmd.op    = bpa_pkg::DP_FB_RDB;
          state_nxt = S_FB_TST;
        end
      end
      S_FB_TST: begin
        if (sts.buddy_free) begin
          cmd.op    = bpa_pkg::DP_FB_ARG_B;
          ret_nxt   = S_FB_MRG;
          state_nxt = S_U0;
        end else begin
          cmd.op    = bpa_pkg::DP_FB_ARG_P;
          ret_nxt   = S_FR_NEXT;
          state_nxt = S_P0;
        end
      end
      S_FB_MRG: begin
        cmd.op    = bpa_pkg::DP_FB_MRG;
        state_nxt = S_FB_CHK;
      end
      S_FR_NEXT: begin
        cmd.op    = bpa_pkg::DP_FR_NEXT;
        state_nxt = S_FR_TOP;
      end
      // format: clear all flags, then carve largest blocks
      S_F_CLR: begin
        cmd.op = bpa_pkg::DP_CLRW;
        if (sts.sw_all) begin
          state_nxt = S_F_CI;
        end
      end
      S_F_CI: begin
        cmd.op    = bpa_pkg::DP_CARVE_INIT;
        state_nxt = S_F_CARVE;
      end
      S_F_CARVE: begin
        if (sts.carve_fit) begin
          cmd.op    = bpa_pkg::DP_F_ARG;
          ret_nxt   = S_F_ADV;
          state_nxt = S_P0;
        end else if (sts.of_zero) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.op = bpa_pkg::DP_OF_DEC;
        end
      end
      S_F_ADV: begin
        cmd.op    = bpa_pkg::DP_FR_NEXT;
        state_nxt = S_F_CARVE;
      end
      // list push and unlink
      S_P0: begin
        cmd.op    = bpa_pkg::DP_P0;
        state_nxt = S_P1;
      end
      S_P1: begin
        cmd.op    = bpa_pkg::DP_P1;
        state_nxt = ret_r;
      end
      S_U0: begin
        state_nxt = S_U1;
      end
      S_U1: begin
        cmd.op    = bpa_pkg::DP_U1;
        state_nxt = ret_r;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.op    = bpa_pkg::DP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_RESULT && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
